// File: design/mcstb_pkg.sv
// shared constants, command and status codes, and control types for the timer bank
// depends on nothing; used by mcstb_ctrl, mcstb_dp and multi_channel_soft_timer_bank
package mcstb_pkg;

  // bank geometry
  localparam int SLOT_COUNT = 8;
  localparam int TIME_WIDTH = 32;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // request opcodes
  localparam logic [3:0] CMD_TICK      = 4'd0;
  localparam logic [3:0] CMD_REGISTER  = 4'd1;
  localparam logic [3:0] CMD_START     = 4'd2;
  localparam logic [3:0] CMD_STOP      = 4'd3;
  localparam logic [3:0] CMD_SET_IVAL  = 4'd4;
  localparam logic [3:0] CMD_UNREG     = 4'd5;
  localparam logic [3:0] CMD_UNREG_ALL = 4'd6;
  localparam logic [3:0] CMD_PROCESS   = 4'd7;
  localparam logic [3:0] CMD_QUERY     = 4'd8;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_ID  = 2'd2;
  localparam logic [1:0] ST_NONE    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // latch the accepted request, seed the scan index
    logic step;   // examine the slot under the scan index
    logic exec;   // apply the request and write the result register
  } mcstb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic new_process;  // request at the input is a process
    logic hit;          // slot under the scan index has expired
    logic out_busy;     // result register holds an untaken result
  } mcstb_stat_t;

endpackage

// File: design/mcstb_ctrl.sv
// controller for the timer bank: accepts requests, sequences the slot scan
// and the final update step; depends on mcstb_pkg
module mcstb_ctrl
  import mcstb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  mcstb_stat_t stat,
  output mcstb_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          count_nxt = '0;
          state_nxt = stat.new_process ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.hit || count_r == LAST_IDX) begin
          state_nxt = S_EXEC;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/mcstb_dp.sv
// datapath for the timer bank: slot table, tick counter, scan pointer,
// expiry check and the result register; depends on mcstb_pkg
module mcstb_dp
  import mcstb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mcstb_cmd_t  cmd,
  output mcstb_stat_t stat,
  input  logic [39:0] in_tdata,
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser
);

  // latched request
  logic [3:0]            cmd_r;
  logic [3:0]            id_r;
  logic [TIME_WIDTH-1:0] ival_r;
  logic                  os_r;

  // scan state
  logic [IDX_W-1:0] cur_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] ptr_r;

  // slot table and time
  logic [SLOT_COUNT-1:0] slot_reg_r;
  logic [SLOT_COUNT-1:0] slot_act_r;
  logic [SLOT_COUNT-1:0] slot_os_r;
  logic [TIME_WIDTH-1:0] slot_ival_r  [SLOT_COUNT];
  logic [TIME_WIDTH-1:0] slot_start_r [SLOT_COUNT];
  logic [TIME_WIDTH-1:0] now_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic        out_fired_r, out_fired_nxt;
  logic        out_run_r, out_run_nxt;
  logic        out_isv_r, out_isv_nxt;
  logic [31:0] out_rb_r, out_rb_nxt;

  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      id_idx;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  expired;
  logic                  id_ok;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_any;
  logic [IDX_W-1:0]      next_idx;

  assign id_idx = id_r[IDX_W-1:0];
  assign id_ok  = {1'b0, id_r} < 5'(SLOT_COUNT);

  // one table read port: scan index during process, request id otherwise
  assign rd_idx  = (cmd_r == CMD_PROCESS) ? cur_idx_r : id_idx;
  assign elapsed = now_r - slot_start_r[rd_idx];
  assign expired = slot_reg_r[rd_idx] && slot_act_r[rd_idx]
                   && (elapsed >= slot_ival_r[rd_idx]);

  assign next_idx = (cur_idx_r == LAST_IDX) ? '0 : cur_idx_r + 1'b1;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_reg_r[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign stat.new_process = (in_tuser[3:0] == CMD_PROCESS);
  assign stat.hit         = expired;
  assign stat.out_busy    = out_valid_r && !out_tready;

  // request latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_tuser[3:0];
      os_r   <= in_tuser[4];
      id_r   <= in_tdata[3:0];
      ival_r <= TIME_WIDTH'(in_tdata[35:4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_idx_r <= '0;
      hit_r     <= 1'b0;
    end else if (cmd.load) begin
      cur_idx_r <= ptr_r;
      hit_r     <= 1'b0;
    end else if (cmd.step) begin
      if (expired) begin
        hit_r <= 1'b1;
      end else begin
        cur_idx_r <= next_idx;
      end
    end
  end

  // table, time and scan pointer updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_reg_r <= '0;
      slot_act_r <= '0;
      slot_os_r  <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_ival_r[i]  <= '0;
        slot_start_r[i] <= '0;
      end
      now_r <= '0;
      ptr_r <= '0;
    end else if (cmd.exec) begin
      case (cmd_r)
        CMD_TICK: begin
          now_r <= now_r + 1'b1;
        end
        CMD_REGISTER: begin
          if (free_any) begin
            slot_reg_r[free_idx]   <= 1'b1;
            slot_os_r[free_idx]    <= os_r;
            slot_act_r[free_idx]   <= os_r;
            slot_ival_r[free_idx]  <= ival_r;
            slot_start_r[free_idx] <= now_r;
          end
        end
        CMD_START: begin
          if (id_ok) begin
            slot_act_r[id_idx]   <= 1'b1;
            slot_start_r[id_idx] <= now_r;
          end
        end
        CMD_STOP: begin
          if (id_ok) begin
            slot_act_r[id_idx] <= 1'b0;
          end
        end
        CMD_SET_IVAL: begin
          if (id_ok) begin
            slot_ival_r[id_idx] <= ival_r;
          end
        end
        CMD_UNREG: begin
          if (id_ok) begin
            slot_reg_r[id_idx]   <= 1'b0;
            slot_act_r[id_idx]   <= 1'b0;
            slot_os_r[id_idx]    <= 1'b0;
            slot_ival_r[id_idx]  <= '0;
            slot_start_r[id_idx] <= '0;
          end
        end
        CMD_UNREG_ALL: begin
          slot_reg_r <= '0;
          slot_act_r <= '0;
          slot_os_r  <= '0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_ival_r[i]  <= '0;
            slot_start_r[i] <= '0;
          end
        end
        CMD_PROCESS: begin
          if (hit_r) begin
            slot_start_r[cur_idx_r] <= now_r;
            if (slot_os_r[cur_idx_r]) begin
              slot_reg_r[cur_idx_r] <= 1'b0;
              slot_act_r[cur_idx_r] <= 1'b0;
            end
            ptr_r <= next_idx;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result fields for the request being applied
  always_comb begin
    out_status_nxt = ST_OK;
    out_slot_nxt   = '0;
    out_fired_nxt  = 1'b0;
    out_run_nxt    = 1'b0;
    out_isv_nxt    = 1'b0;
    out_rb_nxt     = '0;
    case (cmd_r)
      CMD_REGISTER: begin
        if (free_any) begin
          out_slot_nxt = 4'(free_idx);
        end else begin
          out_status_nxt = ST_NO_FREE;
        end
      end
      CMD_START, CMD_STOP, CMD_SET_IVAL, CMD_UNREG: begin
        if (!id_ok) begin
          out_status_nxt = ST_BAD_ID;
        end
      end
      CMD_QUERY: begin
        if (!id_ok) begin
          out_status_nxt = ST_BAD_ID;
        end else begin
          out_isv_nxt = slot_reg_r[id_idx];
          out_run_nxt = slot_reg_r[id_idx] && slot_act_r[id_idx];
          out_rb_nxt  = 32'(slot_ival_r[id_idx]);
        end
      end
      CMD_PROCESS: begin
        if (hit_r) begin
          out_slot_nxt  = 4'(cur_idx_r);
          out_fired_nxt = 1'b1;
        end else begin
          out_status_nxt = ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_fired_r  <= out_fired_nxt;
      out_run_r    <= out_run_nxt;
      out_isv_r    <= out_isv_nxt;
      out_rb_r     <= out_rb_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_rb_r, out_isv_r, out_run_r, out_fired_r, out_slot_r};

endmodule

// File: design/multi_channel_soft_timer_bank.sv
// A request is accepted in the idle state and its result is registered by the exec step, which
// waits while the result register holds an untaken result; a process request first scans the
// slots one slot per cycle (1 to SLOT_COUNT slots examined), stopping at the first expired one.
// A new request is taken while a result waits; the request after that stalls until the waiting
// result is taken.
// Reset (rst_n low, synchronous) frees all slots, clears the tick count and scan pointer.
module multi_channel_soft_timer_bank
  import mcstb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // timer_id[3:0], interval_ticks[35:4], zero fill
  input  logic [4:0]  in_tuser,   // cmd[3:0], one_shot[4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // slot_id[3:0], fired[4], is_running[5], is_valid[6],
                                  // interval_readback[38:7], zero fill
  output logic [1:0]  out_tuser   // status[1:0]
);

  mcstb_cmd_t  cmd;
  mcstb_stat_t stat;

  // request sequencing
  mcstb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot table and result
  mcstb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/sv/multi_channel_soft_timer_bank_tb.sv
// self-checking testbench for the timer slot bank: directed and random requests, with
// result checking against a cycle-free prediction of the slot state
// depends on mcstb_pkg and multi_channel_soft_timer_bank
`timescale 1ns / 100ps

module multi_channel_soft_timer_bank_tb;
  import mcstb_pkg::*;

  localparam int RANDOM_REQUESTS = 600;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_CYCLES     = 300;

  // one result of the bank, unpacked
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_id;
    logic        fired;
    logic        running;
    logic        valid;
    logic [31:0] readback;
  } timer_reply_t;

  // predicted slot state and the replies still owed by the bank
  class timer_bank_scoreboard;
    bit                    slot_reg[SLOT_COUNT];
    bit                    slot_act[SLOT_COUNT];
    bit                    slot_os[SLOT_COUNT];
    logic [TIME_WIDTH-1:0] slot_ival[SLOT_COUNT];
    logic [TIME_WIDTH-1:0] slot_start[SLOT_COUNT];
    logic [TIME_WIDTH-1:0] tick_count;
    int                    scan_ptr;
    timer_reply_t          expected_replies[$];
    int                    mismatches;

    function new();
      for (int s = 0; s < SLOT_COUNT; s++) free_slot(s);
      tick_count = '0;
      scan_ptr   = 0;
      mismatches = 0;
    endfunction

    function void free_slot(int s);
      slot_reg[s]   = 1'b0;
      slot_act[s]   = 1'b0;
      slot_os[s]    = 1'b0;
      slot_ival[s]  = '0;
      slot_start[s] = '0;
    endfunction

    // apply one request to the slot state and work out its reply
    function timer_reply_t predict_reply(logic [3:0] cmd, logic [3:0] id,
                                         logic [31:0] ival, logic os);
      timer_reply_t          r;
      logic [TIME_WIDTH-1:0] elapsed;
      bit                    taken;
      int                    s;
      r     = '0;
      taken = 1'b0;
      case (cmd)
        CMD_TICK: begin
          tick_count = tick_count + 1'b1;
        end
        CMD_REGISTER: begin
          r.status = ST_NO_FREE;
          for (int k = 0; k < SLOT_COUNT && !taken; k++) begin
            if (!slot_reg[k]) begin
              slot_reg[k]   = 1'b1;
              slot_os[k]    = os;
              slot_act[k]   = os;
              slot_ival[k]  = TIME_WIDTH'(ival);
              slot_start[k] = tick_count;
              r.status      = ST_OK;
              r.slot_id     = 4'(k);
              taken         = 1'b1;
            end
          end
        end
        CMD_START, CMD_STOP, CMD_SET_IVAL, CMD_UNREG, CMD_QUERY: begin
          if (id >= SLOT_COUNT) begin
            r.status = ST_BAD_ID;
          end else begin
            case (cmd)
              CMD_START: begin
                slot_act[id]   = 1'b1;
                slot_start[id] = tick_count;
              end
              CMD_STOP:     slot_act[id]  = 1'b0;
              CMD_SET_IVAL: slot_ival[id] = TIME_WIDTH'(ival);
              CMD_UNREG:    free_slot(id);
              default: begin
                r.valid    = slot_reg[id];
                r.running  = slot_reg[id] && slot_act[id];
                r.readback = 32'(slot_ival[id]);
              end
            endcase
          end
        end
        CMD_UNREG_ALL: begin
          for (int k = 0; k < SLOT_COUNT; k++) free_slot(k);
        end
        CMD_PROCESS: begin
          r.status = ST_NONE;
          if (scan_ptr >= SLOT_COUNT) scan_ptr = 0;
          for (int n = 0; n < SLOT_COUNT && !taken; n++) begin
            s        = scan_ptr;
            scan_ptr = (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
            elapsed  = tick_count - slot_start[s];
            if (slot_reg[s] && slot_act[s] && elapsed >= slot_ival[s]) begin
              slot_start[s] = tick_count;
              if (slot_os[s]) begin
                slot_reg[s] = 1'b0;
                slot_act[s] = 1'b0;
              end
              r.status  = ST_OK;
              r.slot_id = 4'(s);
              r.fired   = 1'b1;
              taken     = 1'b1;
            end
          end
        end
        default: ;  // unknown opcode: plain ok reply
      endcase
      return r;
    endfunction

    function void note_request(logic [3:0] cmd, logic [3:0] id, logic [31:0] ival,
                               logic os);
      expected_replies.push_back(predict_reply(cmd, id, ival, os));
    endfunction

    function void check_result(timer_reply_t got);
      timer_reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: status %0d slot %0d", $time,
                   got.status, got.slot_id);
        return;
      end
      want = expected_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch exp st %0d id %0d fired %0b run %0b valid %0b rb %h",
                    " / got st %0d id %0d fired %0b run %0b valid %0b rb %h"}, $time,
                   want.status, want.slot_id, want.fired, want.running, want.valid,
                   want.readback, got.status, got.slot_id, got.fired, got.running,
                   got.valid, got.readback);
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [4:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  timer_bank_scoreboard sb;
  bit gaps_on;
  bit hold_request;
  int hold_left;
  int quiet_cycles;

  multi_channel_soft_timer_bank u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random stalls plus one long hold-off on demand
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 14);
      end
    end
  end

  // monitor: note accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        sb.check_result('{status: out_tuser, slot_id: out_tdata[3:0], fired: out_tdata[4],
                          running: out_tdata[5], valid: out_tdata[6],
                          readback: out_tdata[38:7]});
      end
      if (in_tvalid && in_tready) begin
        quiet_cycles = 0;
        sb.note_request(in_tuser[3:0], in_tdata[3:0], in_tdata[35:4], in_tuser[4]);
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // offer one request and wait until the bank takes it; valid stays high afterwards
  task automatic send_request(input logic [3:0] cmd, input logic [3:0] id,
                              input logic [31:0] ival, input logic os);
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {os, cmd};
    in_tdata  <= {4'b0, ival, id};
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [3:0]  cmd;
    logic [3:0]  id;
    logic [31:0] ival;
    int          pick;
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    gaps_on      = 1'b1;
    hold_request = 1'b0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty bank, fire paths, one-shot freeing, full bank, bad ids
    send_request(CMD_QUERY, 4'd0, 32'd0, 1'b0);
    send_request(CMD_PROCESS, 4'd0, 32'd0, 1'b0);
    send_request(CMD_REGISTER, 4'd0, 32'd0, 1'b0);          // periodic, comes up stopped
    send_request(CMD_PROCESS, 4'd0, 32'd0, 1'b0);
    send_request(CMD_START, 4'd0, 32'd0, 1'b0);
    send_request(CMD_PROCESS, 4'd0, 32'd0, 1'b0);           // zero interval fires at once
    send_request(CMD_REGISTER, 4'd0, 32'hFFFF_FFFF, 1'b1);  // one-shot, largest interval
    send_request(CMD_SET_IVAL, 4'd1, 32'd2, 1'b0);
    send_request(CMD_TICK, 4'd0, 32'd0, 1'b0);
    send_request(CMD_TICK, 4'd0, 32'd0, 1'b0);
    send_request(CMD_PROCESS, 4'd0, 32'd0, 1'b0);           // one-shot fires and frees
    send_request(CMD_QUERY, 4'd1, 32'd0, 1'b0);
    send_request(CMD_START, 4'd3, 32'd0, 1'b0);             // start on a free slot
    for (int k = 1; k < SLOT_COUNT; k++)
      send_request(CMD_REGISTER, 4'd0, (k % 2) ? 32'hAAAA_AAAA : 32'h5555_5555,
                   1'(k % 2));
    send_request(CMD_REGISTER, 4'd0, 32'd7, 1'b0);          // bank full
    send_request(CMD_QUERY, 4'd3, 32'd0, 1'b0);             // register set the run flag from one-shot
    send_request(CMD_STOP, 4'd15, 32'd0, 1'b0);
    send_request(CMD_QUERY, 4'd8, 32'd0, 1'b0);
    send_request(CMD_UNREG, 4'd2, 32'd0, 1'b0);
    send_request(CMD_UNREG_ALL, 4'd0, 32'd0, 1'b0);
    send_request(4'd9, 4'd0, 32'd0, 1'b0);
    send_request(4'd15, 4'd0, 32'd0, 1'b0);

    // random requests, biased toward small intervals so slots really expire
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == 150) hold_request = 1'b1;
      if (i == 350) wait_drained();
      gaps_on = !(i >= 450 && i < 550);
      pick    = $urandom_range(99);
      if (pick < 30)       cmd = CMD_TICK;
      else if (pick < 50)  cmd = CMD_PROCESS;
      else if (pick < 62)  cmd = CMD_REGISTER;
      else if (pick < 70)  cmd = CMD_START;
      else if (pick < 75)  cmd = CMD_STOP;
      else if (pick < 81)  cmd = CMD_SET_IVAL;
      else if (pick < 87)  cmd = CMD_UNREG;
      else if (pick < 95)  cmd = CMD_QUERY;
      else if (pick < 96)  cmd = CMD_UNREG_ALL;
      else                 cmd = 4'($urandom_range(15, 9));
      id   = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8)) : 4'($urandom_range(7));
      ival = ($urandom_range(99) < 85) ? 32'($urandom_range(6)) : $urandom();
      send_request(cmd, id, ival, 1'($urandom_range(1)));
    end

    // drain and let any stray result show up
    wait_drained();
    repeat (SLOT_COUNT + 20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mcstb_pkg.sv
design/mcstb_ctrl.sv
design/mcstb_dp.sv
design/multi_channel_soft_timer_bank.sv
tb/sv/multi_channel_soft_timer_bank_tb.sv
